FILE: hdl/rdm_pkg.sv
// rdm_pkg: shared types and constants of the RGB distance matte core.
// Holds the matte mode codes and the register indexes of the CSR port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rdm_pkg;

   // Register file of the CSR port
   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TOLERANCE = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FALLOFF   = 1'b1;

   // How the matte of one pixel is formed once the distance is known
   typedef enum logic [1:0] {
      MODE_ZERO,
      MODE_BAND,
      MODE_PASS
   } mode_type;

endpackage

`default_nettype wire

FILE: hdl/rdm_dist.sv
// rdm_dist: squared RGB distance front end, three register stages.
// Absolute differences, then squares, then their sum. No package use.
`timescale 1ns / 1ps
`default_nettype none

module rdm_dist #(
   parameter int CHANNEL_BITS = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      adv,
   input  wire logic                      in_valid,
   input  wire logic [CHANNEL_BITS-1:0]   in_image_red,
   input  wire logic [CHANNEL_BITS-1:0]   in_image_green,
   input  wire logic [CHANNEL_BITS-1:0]   in_image_blue,
   input  wire logic [CHANNEL_BITS-1:0]   in_image_alpha,
   input  wire logic [CHANNEL_BITS-1:0]   in_key_red,
   input  wire logic [CHANNEL_BITS-1:0]   in_key_green,
   input  wire logic [CHANNEL_BITS-1:0]   in_key_blue,
   output logic                           out_valid,
   output logic [2*CHANNEL_BITS+1:0]      out_sum,
   output logic [CHANNEL_BITS-1:0]        out_alpha
);

   localparam int C  = CHANNEL_BITS;
   localparam int SW = 2 * CHANNEL_BITS + 2;

   logic [C-1:0]   image_chan [3];
   logic [C-1:0]   key_chan   [3];
   logic [C-1:0]   diff_in    [3];
   logic [C-1:0]   diff_ff    [3];
   logic [2*C-1:0] sq_ff      [3];
   logic [SW-1:0]  sum_in;
   logic [SW-1:0]  sum_ff;
   logic [C-1:0]   alpha_ff   [3];
   logic [2:0]     valid_ff;

   assign image_chan[0] = in_image_red;
   assign image_chan[1] = in_image_green;
   assign image_chan[2] = in_image_blue;
   assign key_chan[0]   = in_key_red;
   assign key_chan[1]   = in_key_green;
   assign key_chan[2]   = in_key_blue;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (image_chan[i] > key_chan[i]) begin
            diff_in[i] = image_chan[i] - key_chan[i];
         end else begin
            diff_in[i] = key_chan[i] - image_chan[i];
         end
      end
      sum_in = SW'(sq_ff[0]) + SW'(sq_ff[1]) + SW'(sq_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            diff_ff[i] <= diff_in[i];
            sq_ff[i]   <= diff_ff[i] * diff_ff[i];
         end
         sum_ff      <= sum_in;
         alpha_ff[0] <= in_image_alpha;
         alpha_ff[1] <= alpha_ff[0];
         alpha_ff[2] <= alpha_ff[1];
      end
   end

   assign out_valid = valid_ff[2];
   assign out_sum   = sum_ff;
   assign out_alpha = alpha_ff[2];

endmodule

`default_nettype wire

FILE: hdl/rdm_isqrt.sv
// rdm_isqrt: pipelined truncating integer square root, one root bit a stage.
// Carries the pixel alpha alongside. No package use.
`timescale 1ns / 1ps
`default_nettype none

module rdm_isqrt #(
   parameter int CHANNEL_BITS = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      adv,
   input  wire logic                      in_valid,
   input  wire logic [2*CHANNEL_BITS+1:0] in_sum,
   input  wire logic [CHANNEL_BITS-1:0]   in_alpha,
   output logic                           out_valid,
   output logic [CHANNEL_BITS:0]          out_root,
   output logic [CHANNEL_BITS-1:0]        out_alpha
);

   localparam int C  = CHANNEL_BITS;
   localparam int RW = CHANNEL_BITS + 1;
   localparam int SW = 2 * CHANNEL_BITS + 2;

   logic [SW-1:0] rem_ff   [RW];
   logic [RW-1:0] root_ff  [RW];
   logic [C-1:0]  alpha_ff [RW];
   logic [RW-1:0] valid_ff;

   genvar k;
   for (k = 0; k < RW; k++) begin : g_stage
      localparam int B = RW - 1 - k;
      logic [SW-1:0] rem_prev;
      logic [SW-1:0] trial;
      logic [SW-1:0] rem_in;
      logic [RW-1:0] root_prev;
      logic [RW-1:0] root_in;
      logic [C-1:0]  alpha_prev;
      logic          valid_prev;

      if (k == 0) begin : g_first
         assign rem_prev   = in_sum;
         assign root_prev  = '0;
         assign alpha_prev = in_alpha;
         assign valid_prev = in_valid;
      end else begin : g_next
         assign rem_prev   = rem_ff[k-1];
         assign root_prev  = root_ff[k-1];
         assign alpha_prev = alpha_ff[k-1];
         assign valid_prev = valid_ff[k-1];
      end

      // (root + 2^B)^2 - root^2, root holding only bits above B
      assign trial = (SW'(root_prev) << (B + 1)) | (SW'(1) << (2 * B));

      always_comb begin
         if (rem_prev >= trial) begin
            rem_in  = rem_prev - trial;
            root_in = root_prev | (RW'(1) << B);
         end else begin
            rem_in  = rem_prev;
            root_in = root_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (adv) begin
            valid_ff[k] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k]   <= rem_in;
            root_ff[k]  <= root_in;
            alpha_ff[k] <= alpha_prev;
         end
      end
   end

   assign out_valid = valid_ff[RW-1];
   assign out_root  = root_ff[RW-1];
   assign out_alpha = alpha_ff[RW-1];

endmodule

`default_nettype wire

FILE: hdl/rdm_div.sv
// rdm_div: pipelined restoring divider for the partial band, one quotient
// bit a stage. Uses mode_type from rdm_pkg to carry the matte mode along.
`timescale 1ns / 1ps
`default_nettype none

module rdm_div
   import rdm_pkg::*;
#(
   parameter int CHANNEL_BITS  = 16,
   parameter int FRACTION_BITS = 12
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      adv,
   input  wire logic [CHANNEL_BITS-1:0]   falloff,
   input  wire logic                      in_valid,
   input  wire mode_type                  in_mode,
   input  wire logic [CHANNEL_BITS-1:0]   in_diff,
   input  wire logic [CHANNEL_BITS-1:0]   in_alpha,
   output logic                           out_valid,
   output mode_type                       out_mode,
   output logic [FRACTION_BITS-1:0]       out_quot,
   output logic [CHANNEL_BITS-1:0]        out_alpha
);

   localparam int C = CHANNEL_BITS;
   localparam int F = FRACTION_BITS;

   logic [C-1:0]  rem_ff   [F];
   logic [F-1:0]  quot_ff  [F];
   logic [C-1:0]  alpha_ff [F];
   mode_type      mode_ff  [F];
   logic [F-1:0]  valid_ff;

   genvar k;
   for (k = 0; k < F; k++) begin : g_stage
      logic [C-1:0] rem_prev;
      logic [F-1:0] quot_prev;
      logic [C-1:0] alpha_prev;
      mode_type     mode_prev;
      logic         valid_prev;
      logic [C:0]   rem_dbl;
      logic [C:0]   rem_sub;
      logic         take;
      logic [C-1:0] rem_in;
      logic [F-1:0] quot_in;

      if (k == 0) begin : g_first
         assign rem_prev   = in_diff;
         assign quot_prev  = '0;
         assign alpha_prev = in_alpha;
         assign mode_prev  = in_mode;
         assign valid_prev = in_valid;
      end else begin : g_next
         assign rem_prev   = rem_ff[k-1];
         assign quot_prev  = quot_ff[k-1];
         assign alpha_prev = alpha_ff[k-1];
         assign mode_prev  = mode_ff[k-1];
         assign valid_prev = valid_ff[k-1];
      end

      // remainder stays below falloff, so it fits the channel width
      always_comb begin
         rem_dbl = {rem_prev, 1'b0};
         rem_sub = rem_dbl - {1'b0, falloff};
         take    = (rem_dbl >= {1'b0, falloff});
         rem_in  = take ? rem_sub[C-1:0] : rem_dbl[C-1:0];
         quot_in = {quot_prev[F-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (adv) begin
            valid_ff[k] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k]   <= rem_in;
            quot_ff[k]  <= quot_in;
            alpha_ff[k] <= alpha_prev;
            mode_ff[k]  <= mode_prev;
         end
      end
   end

   assign out_valid = valid_ff[F-1];
   assign out_mode  = mode_ff[F-1];
   assign out_quot  = quot_ff[F-1];
   assign out_alpha = alpha_ff[F-1];

endmodule

`default_nettype wire

FILE: hdl/rgb_distance_matte_core.sv
// rgb_distance_matte_core: top level of the distance key matte.
// Uses rdm_pkg and instantiates rdm_dist, rdm_isqrt and rdm_div.
//
// Takes one pixel per clock: image RGB plus alpha and a key RGB, all unsigned
// fixed point with FRACTION_BITS fraction bits, and returns one matte alpha per
// pixel, in order. The distance is the truncated square root of the summed
// squared channel differences. Below tolerance the matte is 0, within
// tolerance + falloff it is min((distance - tolerance) / falloff, alpha) with
// a truncating quotient, and beyond that the image alpha passes through.
// Throughput is one item per cycle while the output is not stalled. In order the
// pipeline holds registers for the differences, squares and sum, the square root
// pipeline with a stage per root bit, the classify register, the divider with a
// stage per quotient bit, and the output register. The whole pipeline
// holds while a result waits at the output. Write tolerance and falloff only
// while no item is in flight.
`timescale 1ns / 1ps
`default_nettype none

module rgb_distance_matte_core
   import rdm_pkg::*;
#(
   parameter int CHANNEL_BITS  = 16,
   parameter int FRACTION_BITS = 12
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [CHANNEL_BITS-1:0]   req_image_red,
   input  wire logic [CHANNEL_BITS-1:0]   req_image_green,
   input  wire logic [CHANNEL_BITS-1:0]   req_image_blue,
   input  wire logic [CHANNEL_BITS-1:0]   req_image_alpha,
   input  wire logic [CHANNEL_BITS-1:0]   req_key_red,
   input  wire logic [CHANNEL_BITS-1:0]   req_key_green,
   input  wire logic [CHANNEL_BITS-1:0]   req_key_blue,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [CHANNEL_BITS-1:0]        rsp_matte_alpha,
   input  wire logic                      csr_write_enable,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CHANNEL_BITS-1:0]   csr_data
);

   localparam int C  = CHANNEL_BITS;
   localparam int F  = FRACTION_BITS;
   localparam int RW = CHANNEL_BITS + 1;
   localparam int SW = 2 * CHANNEL_BITS + 2;
   localparam int MW = (CHANNEL_BITS > FRACTION_BITS) ? CHANNEL_BITS : FRACTION_BITS;

   logic          adv;
   logic [C-1:0]  tol_ff;
   logic [C-1:0]  fall_ff;

   logic          sum_valid;
   logic [SW-1:0] sum_val;
   logic [C-1:0]  sum_alpha;

   logic          root_valid;
   logic [RW-1:0] root_val;
   logic [C-1:0]  root_alpha;

   logic          dec_valid_ff;
   mode_type      dec_mode_ff;
   mode_type      dec_mode_in;
   logic [C-1:0]  dec_diff_ff;
   logic [C-1:0]  dec_diff_in;
   logic [C-1:0]  dec_alpha_ff;
   logic [RW-1:0] tol_ext;
   logic [RW-1:0] limit;
   logic [RW-1:0] diff_full;

   logic          div_valid;
   mode_type      div_mode;
   logic [F-1:0]  div_quot;
   logic [C-1:0]  div_alpha;
   logic [MW-1:0] quot_ext;
   logic [MW-1:0] alpha_ext;

   logic          rsp_valid_ff;
   logic [C-1:0]  rsp_matte_ff;
   logic [C-1:0]  rsp_matte_in;

   // one shared enable: advance the whole pipeline unless the output is stuck
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff  <= '0;
         fall_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_TOLERANCE: tol_ff  <= csr_data;
            CSR_FALLOFF:   fall_ff <= csr_data;
            default: ;
         endcase
      end
   end

   rdm_dist #(
      .CHANNEL_BITS(C)
   ) u_dist (
      .clock         (clock),
      .reset         (reset),
      .adv           (adv),
      .in_valid      (req_valid),
      .in_image_red  (req_image_red),
      .in_image_green(req_image_green),
      .in_image_blue (req_image_blue),
      .in_image_alpha(req_image_alpha),
      .in_key_red    (req_key_red),
      .in_key_green  (req_key_green),
      .in_key_blue   (req_key_blue),
      .out_valid     (sum_valid),
      .out_sum       (sum_val),
      .out_alpha     (sum_alpha)
   );

   rdm_isqrt #(
      .CHANNEL_BITS(C)
   ) u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (sum_valid),
      .in_sum   (sum_val),
      .in_alpha (sum_alpha),
      .out_valid(root_valid),
      .out_root (root_val),
      .out_alpha(root_alpha)
   );

   // classify the distance against the band
   always_comb begin
      tol_ext   = RW'(tol_ff);
      limit     = tol_ext + RW'(fall_ff);
      diff_full = root_val - tol_ext;
      dec_diff_in = diff_full[C-1:0];
      if (root_val < tol_ext) begin
         dec_mode_in = MODE_ZERO;
      end else if (root_val < limit && fall_ff != '0) begin
         dec_mode_in = MODE_BAND;
      end else begin
         dec_mode_in = MODE_PASS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dec_valid_ff <= 1'b0;
      end else if (adv) begin
         dec_valid_ff <= root_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dec_mode_ff  <= dec_mode_in;
         dec_diff_ff  <= dec_diff_in;
         dec_alpha_ff <= root_alpha;
      end
   end

   rdm_div #(
      .CHANNEL_BITS (C),
      .FRACTION_BITS(F)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .falloff  (fall_ff),
      .in_valid (dec_valid_ff),
      .in_mode  (dec_mode_ff),
      .in_diff  (dec_diff_ff),
      .in_alpha (dec_alpha_ff),
      .out_valid(div_valid),
      .out_mode (div_mode),
      .out_quot (div_quot),
      .out_alpha(div_alpha)
   );

   always_comb begin
      quot_ext  = MW'(div_quot);
      alpha_ext = MW'(div_alpha);
      case (div_mode)
         MODE_ZERO: rsp_matte_in = '0;
         MODE_BAND: rsp_matte_in = (quot_ext < alpha_ext) ? quot_ext[C-1:0] : div_alpha;
         default:   rsp_matte_in = div_alpha;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_matte_ff <= rsp_matte_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_matte_alpha = rsp_matte_ff;

`ifndef SYNTHESIS
   a_reset_empties_output: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_ready_follows_output: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("input ready does not track the output stall");

   a_band_diff_below_falloff: assert property (@(posedge clock) disable iff (reset)
      dec_valid_ff && dec_mode_ff == MODE_BAND && $past(adv) && !$past(csr_write_enable)
      |-> dec_diff_ff < fall_ff && fall_ff != '0)
      else $error("band item with distance offset not below falloff");
`endif

endmodule

`default_nettype wire

FILE: tb/tb.sv
// tb: self-checking bench for rgb_distance_matte_core.
// Holds the matte scoreboard class, the valid/ready drivers and the CSR writer.
// Depends on rdm_pkg and the core RTL.
`timescale 1ns / 1ps

module tb
   import rdm_pkg::*;
();

   localparam int CHAN_W      = 16;
   localparam int FRAC_W      = 12;
   localparam int STALL_PCT   = 17;
   localparam int QUIET_LIMIT = 2000;
   localparam int PIPE_DEPTH  = CHAN_W + FRAC_W + 6;
   localparam int PHASE_ITEMS = 200;

   typedef logic [CHAN_W-1:0] chan_type;

   typedef struct packed {
      chan_type image_red;
      chan_type image_green;
      chan_type image_blue;
      chan_type image_alpha;
      chan_type key_red;
      chan_type key_green;
      chan_type key_blue;
   } pixel_type;

   // Register settings swept by the random phases; a last phase picks random values
   localparam chan_type TOL_SET [8] = '{16'd4096, 16'd4096, 16'hFFFF, 16'd0,
                                        16'd0, 16'hFFFF, 16'd1, 16'd300};
   localparam chan_type FAL_SET [8] = '{16'd8192, 16'd0, 16'hFFFF, 16'd0,
                                        16'hFFFF, 16'd0, 16'd1, 16'd20000};

   class matte_scoreboard;
      chan_type tolerance;
      chan_type falloff;
      chan_type expected_mattes[$];
      int       errors;

      function new();
         tolerance = '0;
         falloff   = '0;
         errors    = 0;
      endfunction

      function void set_reg(logic [CSR_INDEX_BITS-1:0] index, chan_type value);
         case (index)
            CSR_TOLERANCE: tolerance = value;
            CSR_FALLOFF:   falloff = value;
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_mattes.size();
      endfunction

      // Distance keeps full precision (up to 17 bits); the band quotient stays below 1.0.
      function void note_pixel(pixel_type p);
         longint unsigned sum, root, trial, diff, ratio, band_top;
         chan_type img [3];
         chan_type key [3];
         chan_type matte;
         img = '{p.image_red, p.image_green, p.image_blue};
         key = '{p.key_red, p.key_green, p.key_blue};
         sum = 0;
         for (int i = 0; i < 3; i++) begin
            diff = (img[i] > key[i]) ? longint'(img[i]) - longint'(key[i])
                                     : longint'(key[i]) - longint'(img[i]);
            sum += diff * diff;
         end
         root = 0;
         for (int b = 17; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= sum) begin
               root = trial;
            end
         end
         band_top = longint'(tolerance) + longint'(falloff);
         if (root < longint'(tolerance)) begin
            matte = '0;
         end else if (falloff != '0 && root < band_top) begin
            ratio = ((root - longint'(tolerance)) << FRAC_W) / longint'(falloff);
            matte = (ratio < longint'(p.image_alpha)) ? chan_type'(ratio) : p.image_alpha;
         end else begin
            matte = p.image_alpha;
         end
         expected_mattes.push_back(matte);
      endfunction

      function void check_matte(chan_type got);
         chan_type want;
         if (expected_mattes.size() == 0) begin
            errors++;
            if (errors <= 10) begin
               $display("matte %0d arrived with no pixel outstanding", got);
            end
         end else begin
            want = expected_mattes.pop_front();
            if (got !== want) begin
               errors++;
               if (errors <= 10) begin
                  $display("matte_alpha mismatch: expected %0d, actual %0d", want, got);
               end
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   chan_type req_image_red = '0;
   chan_type req_image_green = '0;
   chan_type req_image_blue = '0;
   chan_type req_image_alpha = '0;
   chan_type req_key_red = '0;
   chan_type req_key_green = '0;
   chan_type req_key_blue = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   chan_type rsp_matte_alpha;
   logic csr_write_enable = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_TOLERANCE;
   chan_type csr_data = '0;

   matte_scoreboard matte_board;
   bit calm = 1'b0;
   int quiet_cycles = 0;

   rgb_distance_matte_core #(
      .CHANNEL_BITS  (CHAN_W),
      .FRACTION_BITS (FRAC_W)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_image_red    (req_image_red),
      .req_image_green  (req_image_green),
      .req_image_blue   (req_image_blue),
      .req_image_alpha  (req_image_alpha),
      .req_key_red      (req_key_red),
      .req_key_green    (req_key_green),
      .req_key_blue     (req_key_blue),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_matte_alpha  (rsp_matte_alpha),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #1 clock = ~clock;

   always @(negedge clock) begin
      rsp_ready = calm || ($urandom_range(0, 99) >= STALL_PCT);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         matte_board.check_matte(rsp_matte_alpha);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic pixel_type make_pixel(chan_type ir, chan_type ig, chan_type ib,
                                            chan_type ia, chan_type kr, chan_type kg,
                                            chan_type kb);
      pixel_type p;
      p = '{ir, ig, ib, ia, kr, kg, kb};
      return p;
   endfunction

   // Place an image/key pair a given distance apart, in either order
   function automatic void place_channel(int unsigned delta, output chan_type img,
                                         output chan_type key);
      chan_type base;
      if (delta > 65535) begin
         delta = 65535;
      end
      base = chan_type'($urandom_range(0, 65535 - delta));
      if ($urandom_range(0, 1) == 1) begin
         img = base + chan_type'(delta);
         key = base;
      end else begin
         key = base + chan_type'(delta);
         img = base;
      end
   endfunction

   task automatic send_pixel(pixel_type p);
      @(negedge clock);
      while (!calm && $urandom_range(0, 99) < STALL_PCT) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      {req_image_red, req_image_green, req_image_blue, req_image_alpha,
       req_key_red, req_key_green, req_key_blue} = p;
      do @(posedge clock); while (!req_ready);
      matte_board.note_pixel(p);
   endtask

   // Hold off the sender until every outstanding matte is back
   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (matte_board.pending() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic write_reg(logic [CSR_INDEX_BITS-1:0] index, chan_type value);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index = index;
      csr_data = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
      matte_board.set_reg(index, value);
   endtask

   task automatic configure(chan_type tol, chan_type fal);
      drain();
      write_reg(CSR_TOLERANCE, tol);
      write_reg(CSR_FALLOFF, fal);
   endtask

   initial begin
      pixel_type p;
      int unsigned reach;
      int unsigned delta [3];
      int unsigned pick;

      matte_board = new();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Band from 1.0 to 3.0
      configure(16'd4096, 16'd8192);
      send_pixel(make_pixel('0, '0, '0, '0, '0, '0, '0));
      send_pixel(make_pixel('1, '1, '1, '1, '1, '1, '1));
      send_pixel(make_pixel('1, '1, '1, '1, '0, '0, '0));
      send_pixel(make_pixel('1, '1, '1, '0, '0, '0, '0));
      send_pixel(make_pixel(16'd4095, '0, '0, '1, '0, '0, '0));
      send_pixel(make_pixel(16'd4096, '0, '0, '1, '0, '0, '0));
      send_pixel(make_pixel(16'd4097, '0, '0, '1, '0, '0, '0));
      send_pixel(make_pixel('0, 16'd12287, '0, '1, '0, '0, '0));
      send_pixel(make_pixel('0, '0, 16'd12287, 16'd100, '0, '0, '0));
      send_pixel(make_pixel('0, '0, 16'd12288, 16'h1234, '0, '0, '0));
      send_pixel(make_pixel('0, '0, '0, '1, '0, '0, 16'd10000));
      send_pixel(make_pixel(16'd5000, 16'd6000, 16'd7000, '1,
                            16'd1000, 16'd2000, 16'd3000));

      // Zero falloff: hard cut at the tolerance
      configure(16'd4096, 16'd0);
      send_pixel(make_pixel(16'd4095, '0, '0, '1, '0, '0, '0));
      send_pixel(make_pixel(16'd4096, '0, '0, 16'd777, '0, '0, '0));
      send_pixel(make_pixel('0, 16'd50000, '0, 16'h8001, '0, '0, '0));

      // Full-scale registers: distance wider than a channel lands in the band
      configure('1, '1);
      send_pixel(make_pixel('1, '1, '1, '1, '0, '0, '0));
      send_pixel(make_pixel('0, '0, '0, '1, '1, '1, '1));
      send_pixel(make_pixel('1, '0, '0, '1, '0, '0, '0));

      for (int ph = 0; ph < 9; ph++) begin
         if (ph < 8) begin
            configure(TOL_SET[ph], FAL_SET[ph]);
         end else begin
            configure(chan_type'($urandom), chan_type'($urandom));
         end
         calm = (ph == 2);
         reach = int'(matte_board.tolerance) + int'(matte_board.falloff)
               + int'(matte_board.falloff) / 4 + 64;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (ph == 4 && n == PHASE_ITEMS / 2) begin
               drain();
            end
            p.image_red   = chan_type'($urandom);
            p.image_green = chan_type'($urandom);
            p.image_blue  = chan_type'($urandom);
            p.image_alpha = chan_type'($urandom);
            p.key_red     = chan_type'($urandom);
            p.key_green   = chan_type'($urandom);
            p.key_blue    = chan_type'($urandom);
            // Most pixels sit near the key so the distance falls around the band
            if ($urandom_range(0, 9) >= 3) begin
               if ($urandom_range(0, 1) == 1) begin
                  delta = '{0, 0, 0};
                  pick = $urandom_range(0, 2);
                  delta[pick] = $urandom_range(0, reach);
               end else begin
                  for (int c = 0; c < 3; c++) begin
                     delta[c] = $urandom_range(0, reach * 2 / 3);
                  end
               end
               place_channel(delta[0], p.image_red, p.key_red);
               place_channel(delta[1], p.image_green, p.key_green);
               place_channel(delta[2], p.image_blue, p.key_blue);
               if ($urandom_range(0, 1) == 1) begin
                  p.image_alpha = chan_type'($urandom_range(0, 4096));
               end
            end
            send_pixel(p);
         end
      end
      calm = 1'b0;

      drain();
      repeat (PIPE_DEPTH + 8) @(posedge clock);
      if (matte_board.errors == 0 && matte_board.pending() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

FILE: sim.f
hdl/rdm_pkg.sv
hdl/rdm_dist.sv
hdl/rdm_isqrt.sv
hdl/rdm_div.sv
hdl/rgb_distance_matte_core.sv
tb/tb.sv
